@@ rtl/core/cau_pkg.sv @@
// shared types and constants for the complex arithmetic unit
package cau_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned CmdW  = 3;

  typedef enum logic [CmdW-1:0] {
    CMD_ADD  = 3'd0,
    CMD_SUB  = 3'd1,
    CMD_MUL  = 3'd2,
    CMD_DIV  = 3'd3,
    CMD_GT   = 3'd4,
    CMD_EQ   = 3'd5,
    CMD_LT   = 3'd6,
    CMD_NONE = 3'd7
  } cmd_t;

  typedef struct packed {
    logic [CmdW-1:0]         cmd;
    logic signed [DataW-1:0] a_re;
    logic signed [DataW-1:0] a_im;
    logic signed [DataW-1:0] b_re;
    logic signed [DataW-1:0] b_im;
  } cau_in_t;

  typedef struct packed {
    logic signed [DataW-1:0] res_re;
    logic signed [DataW-1:0] res_im;
    logic                    truth;
    logic                    div_zero;
    logic                    overflow;
  } cau_out_t;

  // saturate a signed wide value given its sign and magnitude fits check
  function automatic logic [DataW:0] sat_mag(input logic neg, input logic big,
                                             input logic [DataW:0] mag);
    // returns {ov, value}
    logic [DataW:0] r;
    if (neg) begin
      if (big || mag > {1'b0, 1'b1, {(DataW-1){1'b0}}}) begin
        r = {1'b1, 1'b1, {(DataW-1){1'b0}}};
      end else begin
        r = {1'b0, DataW'(-mag[DataW-1:0])};
      end
    end else begin
      if (big || mag > {2'b00, {(DataW-1){1'b1}}}) begin
        r = {1'b1, 1'b0, {(DataW-1){1'b1}}};
      end else begin
        r = {1'b0, mag[DataW-1:0]};
      end
    end
    return r;
  endfunction

endpackage

@@ rtl/core/cau_stream_if.sv @@
// valid/ready stream channel carrying a packed payload
interface cau_stream_if #(
  parameter int unsigned W = 1
) (
  input logic clk
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/complex_arith_unit_top.sv @@
// complex arithmetic unit top level
// Complex ALU on signed fixed-point operands with FRAC_BITS fraction bits.
// Channels: in_ch carries cmd and operands a, b; out_ch carries res_re,
// res_im, truth, div_zero and overflow. A transfer happens when valid and
// ready are both high.
// Throughput: one item per cycle while the receiver does not stall. Every
// command goes through the same pipeline: three front stages (operand
// register, multipliers, adders), then 64+FRAC_BITS divider stages (one
// quotient bit each), then the saturation logic feeding the output
// register.
// The whole pipeline advances together; when the receiver stalls with a
// result waiting, the pipeline holds and in_ch ready drops, so nothing is
// lost or repeated. The pipeline also advances while the output register
// is empty.
// Reset clears all valid bits; no item is in flight after reset.
module complex_arith_unit_top #(
  parameter int unsigned FRAC_BITS = 16
) (
  input logic clk,
  input logic rst,
  cau_stream_if.sink   in_ch,
  cau_stream_if.source out_ch
);
  import cau_pkg::*;

  localparam int unsigned NW = 64 + FRAC_BITS;
  localparam int unsigned TW = 3 + 1 + 1 + 1 + 1;

  logic en;
  logic fv;
  logic [2:0] cmd;
  logic [33:0] s_re, s_im;
  logic [65:0] p_re, p_im;
  logic [64:0] ma, mb;
  logic eq;
  cau_in_t in_d;

  assign in_d = cau_in_t'(in_ch.data);
  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  cau_front u_front (
    .clk, .rst, .en,
    .in_valid (in_ch.valid),
    .in_data  (in_d),
    .out_valid(fv),
    .cmd, .s_re, .s_im, .p_re, .p_im, .ma, .mb, .eq
  );

  // signs and magnitudes; the divider carries real-part and a side lane
  logic neg_re, neg_im;
  logic [64:0] mag_re, mag_im;
  assign neg_re = p_re[65];
  assign neg_im = p_im[65];
  assign mag_re = neg_re ? 65'(-p_re) : p_re[64:0];
  assign mag_im = neg_im ? 65'(-p_im) : p_im[64:0];

  // products are at most 2^63 magnitude, so 64 bits suffice
  logic [NW-1:0] num_re, num_im;
  assign num_re = {mag_re[63:0], {FRAC_BITS{1'b0}}};
  assign num_im = {mag_im[63:0], {FRAC_BITS{1'b0}}};

  logic [63:0] den;
  logic dz;
  assign dz  = (mb == '0);
  assign den = dz ? 64'd1 : mb[63:0];

  logic truth0;
  always_comb begin
    case (cmd)
      CMD_GT:  truth0 = ma > mb;
      CMD_LT:  truth0 = ma < mb;
      CMD_EQ:  truth0 = eq;
      default: truth0 = 1'b0;
    endcase
  end

  // side tag: cmd, neg flags, truth, dz; add/sub sums ride in the other divider
  logic [TW-1:0] tag_in, tag_out;
  logic [NW-1:0] q_re, q_im, n2_re, n2_im;
  logic dv, dv2;
  logic [TW-1:0] tag2;
  logic [67:0] sums_in, sums_out;

  assign tag_in = {cmd, neg_re, neg_im, truth0, dz};

  // mul results need no division: pass them through with den of one and
  // the numerator without the fraction padding; multiply wants
  // >> FRAC_BITS, applied in the final stage
  logic is_div;
  assign is_div = (cmd == CMD_DIV);
  assign sums_in = {s_re, s_im};

  cau_div #(.NW(NW), .DW(64), .TW(TW)) u_div_re (
    .clk, .rst, .en,
    .in_valid(fv),
    .num(is_div ? num_re : NW'(mag_re[63:0])),
    .den(is_div ? den : 64'd1),
    .tag(tag_in),
    .out_valid(dv),
    .quo(q_re),
    .out_tag(tag_out)
  );

  cau_div #(.NW(NW), .DW(64), .TW(68)) u_div_im (
    .clk, .rst, .en,
    .in_valid(fv),
    .num(is_div ? num_im : NW'(mag_im[63:0])),
    .den(is_div ? den : 64'd1),
    .tag(sums_in),
    .out_valid(dv2),
    .quo(q_im),
    .out_tag(sums_out)
  );

  assign n2_re = q_re;
  assign n2_im = q_im;
  assign tag2  = tag_out;

  // final stage: shift for multiply, saturate, select by command
  logic [2:0] c_o;
  logic nr, ni, tr, dzo;
  assign {c_o, nr, ni, tr, dzo} = tag2[TW-1:TW-7];

  logic [NW-1:0] sh_re, sh_im;
  assign sh_re = (c_o == CMD_MUL) ? (n2_re >> FRAC_BITS) : n2_re;
  assign sh_im = (c_o == CMD_MUL) ? (n2_im >> FRAC_BITS) : n2_im;

  logic [32:0] sat_re, sat_im, sat_sre, sat_sim;
  logic [33:0] sre, sim;
  logic [33:0] are_m, aim_m;
  assign sre = sums_out[67:34];
  assign sim = sums_out[33:0];
  assign are_m = sre[33] ? 34'(-sre) : sre;
  assign aim_m = sim[33] ? 34'(-sim) : sim;
  assign sat_re  = sat_mag(nr, |sh_re[NW-1:33], sh_re[32:0]);
  assign sat_im  = sat_mag(ni, |sh_im[NW-1:33], sh_im[32:0]);
  assign sat_sre = sat_mag(sre[33], are_m[33], are_m[32:0]);
  assign sat_sim = sat_mag(sim[33], aim_m[33], aim_m[32:0]);

  cau_out_t o_next, o_q;
  always_comb begin
    o_next = '0;
    case (c_o)
      CMD_ADD, CMD_SUB: begin
        o_next.res_re   = sat_sre[31:0];
        o_next.res_im   = sat_sim[31:0];
        o_next.overflow = sat_sre[32] | sat_sim[32];
      end
      CMD_MUL: begin
        o_next.res_re   = sat_re[31:0];
        o_next.res_im   = sat_im[31:0];
        o_next.overflow = sat_re[32] | sat_im[32];
      end
      CMD_DIV: begin
        if (dzo) begin
          o_next.div_zero = 1'b1;
        end else begin
          o_next.res_re   = sat_re[31:0];
          o_next.res_im   = sat_im[31:0];
          o_next.overflow = sat_re[32] | sat_im[32];
        end
      end
      CMD_GT, CMD_EQ, CMD_LT: begin
        o_next.truth = tr;
      end
      default: o_next = '0;
    endcase
  end

  logic ov_q;
  always_ff @(posedge clk) begin
    if (rst) begin
      ov_q <= 1'b0;
    end else if (en) begin
      ov_q <= dv & dv2;
    end
    if (en) begin
      o_q <= o_next;
    end
  end

  assign out_ch.valid = ov_q;
  assign out_ch.data  = o_q;
endmodule

@@ rtl/core/cau_div.sv @@
// pipelined restoring divider, one quotient bit per stage
module cau_div #(
  parameter int unsigned NW = 96,
  parameter int unsigned DW = 64,
  parameter int unsigned TW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [TW-1:0] tag,
  output logic          out_valid,
  output logic [NW-1:0] quo,
  output logic [TW-1:0] out_tag
);
  logic [NW-1:0] n_q [NW+1];
  logic [DW:0]   r_q [NW+1];
  logic [DW-1:0] d_q [NW+1];
  logic [TW-1:0] t_q [NW+1];
  logic          v_q [NW+1];

  always_comb begin
    n_q[0] = num;
    r_q[0] = '0;
    d_q[0] = den;
    t_q[0] = tag;
    v_q[0] = in_valid;
  end

  for (genvar i = 0; i < NW; i++) begin : g_stage
    logic [DW+1:0] sh;
    logic [DW+1:0] diff;
    logic [NW-1:0] n;
    logic [DW:0]   r;
    logic [DW-1:0] d;
    logic [TW-1:0] t;
    logic          v;
    assign sh   = {r_q[i], n_q[i][NW-1]};
    assign diff = sh - {2'b00, d_q[i]};
    always_ff @(posedge clk) begin
      if (rst) begin
        v <= 1'b0;
      end else if (en) begin
        v <= v_q[i];
      end
      if (en) begin
        if (!diff[DW+1]) begin
          r <= diff[DW:0];
          n <= {n_q[i][NW-2:0], 1'b1};
        end else begin
          r <= sh[DW:0];
          n <= {n_q[i][NW-2:0], 1'b0};
        end
        d <= d_q[i];
        t <= t_q[i];
      end
    end
    always_comb begin
      n_q[i+1] = n;
      r_q[i+1] = r;
      d_q[i+1] = d;
      t_q[i+1] = t;
      v_q[i+1] = v;
    end
  end

  assign out_valid = v_q[NW];
  assign quo       = n_q[NW];
  assign out_tag   = t_q[NW];
endmodule

@@ rtl/core/cau_front.sv @@
// input stages: sums, products and squared magnitudes
module cau_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  cau_pkg::cau_in_t in_data,
  output logic           out_valid,
  output logic [2:0]     cmd,
  output logic [33:0]    s_re,
  output logic [33:0]    s_im,
  output logic [65:0]    p_re,
  output logic [65:0]    p_im,
  output logic [64:0]    ma,
  output logic [64:0]    mb,
  output logic           eq
);
  import cau_pkg::*;

  // stage 1: register operands
  cau_in_t      s1;
  logic         v1;
  // stage 2: eight products
  logic signed [63:0] m_rr, m_ii, m_ri, m_ir, m_aa, m_ab, m_bb, m_bc;
  logic [2:0]   c2;
  logic signed [32:0] ad_re, ad_im, sb_re, sb_im;
  logic         eq2, v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
    if (en) begin
      s1   <= in_data;
      c2   <= s1.cmd;
      m_rr <= s1.a_re * s1.b_re;
      m_ii <= s1.a_im * s1.b_im;
      m_ri <= s1.a_re * s1.b_im;
      m_ir <= s1.a_im * s1.b_re;
      m_aa <= s1.a_re * s1.a_re;
      m_ab <= s1.a_im * s1.a_im;
      m_bb <= s1.b_re * s1.b_re;
      m_bc <= s1.b_im * s1.b_im;
      ad_re <= 33'(s1.a_re) + 33'(s1.b_re);
      ad_im <= 33'(s1.a_im) + 33'(s1.b_im);
      sb_re <= 33'(s1.a_re) - 33'(s1.b_re);
      sb_im <= 33'(s1.a_im) - 33'(s1.b_im);
      eq2   <= (s1.a_re == s1.b_re) && (s1.a_im == s1.b_im);
      // stage 3: combine
      cmd <= c2;
      eq  <= eq2;
      s_re <= (c2 == CMD_SUB) ? 34'(sb_re) : 34'(ad_re);
      s_im <= (c2 == CMD_SUB) ? 34'(sb_im) : 34'(ad_im);
      ma <= 65'($unsigned(m_aa)) + 65'($unsigned(m_ab));
      mb <= 65'($unsigned(m_bb)) + 65'($unsigned(m_bc));
      if (c2 == CMD_DIV) begin
        p_re <= 66'(m_rr) + 66'(m_ii);
        p_im <= 66'(m_ir) - 66'(m_ri);
      end else begin
        p_re <= 66'(m_rr) - 66'(m_ii);
        p_im <= 66'(m_ri) + 66'(m_ir);
      end
    end
  end
endmodule
